@@ rtl/crh_pkg.sv @@
// Package: shared constants and helpers for the closest rectangle hit block.
`timescale 1ns / 1ps
package crh_pkg;
  localparam int MAX_OBJECTS_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int WORDS           = 5;
  localparam int CW              = 28;  // coordinate width
  localparam int DW              = 18;  // direction width

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TRACE = 1'b1;

  localparam logic [2:0] WSEL_AXIS  = 3'd0;
  localparam logic [2:0] WSEL_LOA   = 3'd1;
  localparam logic [2:0] WSEL_HIA   = 3'd2;
  localparam logic [2:0] WSEL_LOB   = 3'd3;
  localparam logic [2:0] WSEL_HIB   = 3'd4;
  localparam logic [2:0] WSEL_PLANE = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Saturate a wide signed value into the 28-bit point range.
  function automatic logic signed [CW-1:0] sat_pt(input logic signed [71:0] v);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sd134217727;
    lo = -72'sd134217728;
    if (v > hi) sat_pt = CW'(hi);
    else if (v < lo) sat_pt = CW'(lo);
    else sat_pt = v[CW-1:0];
  endfunction
endpackage

@@ rtl/closest_rectangle_hit.sv @@
// Top level of the closest rectangle hit block.
`timescale 1ns / 1ps
// Closest rectangle hit.
// s_axis carries requests. tuser = operation (0 table write, 1 trace).
// A write stores one word of a table entry (axis, bounds, plane) in RAM and
// produces no result. A trace searches entries 0 .. object_count-1 and returns
// one result on m_axis: nearest hit index, distance, face normal, backed-off
// point. A trace passes each entry in turn through the serial divider (one
// quotient bit per cycle, NW = 28 + FRAC_BITS + 1 bits), two multiplies for
// the hit coordinates and four bound compares; a final point stage then uses
// one multiplier for one axis at a time. An entry that fails the plane check
// skips the divider and the later steps.
// Requests are taken one at a time; s_axis_tready is low while a request is
// in work. A finished result waiting in the output register does not hold off
// the next request; a later trace keeps its result until the register empties.
// When m_axis_tready is low the result holds stable in that register.
// cfg writes object_count (clamped to MAX_OBJECTS) and are made while idle.
// Reset (rst, synchronous, active high) clears control state and
// object_count; table entries are undefined until written (no clearing pass).
module closest_rectangle_hit
  import crh_pkg::*;
#(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [5:0]   cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index[4:0], word_select[7:5], word_value[35:8], excluded_index[41:36],
  // origin_x[69:42], origin_y[97:70], origin_z[125:98],
  // direction_x[143:126], direction_y[161:144], direction_z[179:162], pad
  input  logic [183:0] s_axis_tdata,
  input  logic         s_axis_tuser,  // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_flag[0], hit_index[5:1], distance[36:6], normal_axis[38:37],
  // normal_negative[39], point_x[67:40], point_y[95:68], point_z[123:96], pad
  output logic [127:0] m_axis_tdata
);
  localparam int AW   = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int BAW  = $clog2(MAX_OBJECTS * WORDS);
  localparam int NW   = CW + 1 + FRAC_BITS;     // numerator magnitude width
  localparam int CAW  = NW + DW - FRAC_BITS + 2; // exact hit coordinate width
  localparam int BACKOFF = ((1 << FRAC_BITS) + 50) / 100;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RDAX  = 4'd1;  // read axis, plane
  localparam logic [3:0] ST_CHK   = 4'd2;  // check and start divide
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;  // hit coordinates
  localparam logic [3:0] ST_BND   = 4'd5;  // read bounds serially
  localparam logic [3:0] ST_NEXT  = 4'd6;
  localparam logic [3:0] ST_PT    = 4'd7;  // point, one axis a cycle
  localparam logic [3:0] ST_OUT   = 4'd8;
  localparam logic [3:0] ST_WR    = 4'd9;

  // Request fields
  logic [4:0]             f_entry;
  logic [2:0]             f_wsel;
  logic signed [CW-1:0]   f_wval;
  assign f_entry = s_axis_tdata[4:0];
  assign f_wsel  = s_axis_tdata[7:5];
  assign f_wval  = s_axis_tdata[35:8];

  logic [3:0] state;
  logic [5:0] object_count;
  logic [5:0] excl;
  logic signed [CW-1:0] o [3];
  logic signed [DW-1:0] d [3];
  logic [6:0] cnt_lim;
  logic [7:0] idx;
  logic [2:0] sub;
  logic       found;
  logic [NW-1:0] best_t;
  logic [AW-1:0] best_i;
  logic [1:0]    best_ax;
  logic [NW-1:0] tm;
  logic [1:0]    ax;
  logic signed [CAW-1:0] ca, cb;
  logic          inb;
  logic [123:40] out_data;

  // RAMs
  logic          ax_we, bd_we;
  logic [AW-1:0] ax_waddr, ax_raddr;
  logic [1:0]    ax_rdata;
  logic [BAW-1:0] bd_waddr, bd_raddr;
  logic [CW-1:0]  bd_rdata;

  crh_ram #(.WIDTH(2), .DEPTH(MAX_OBJECTS)) u_axis_ram (
    .clk(clk), .we(ax_we), .waddr(ax_waddr), .wdata(f_wval[1:0]),
    .raddr(ax_raddr), .rdata(ax_rdata)
  );
  crh_ram #(.WIDTH(CW), .DEPTH(MAX_OBJECTS * WORDS)) u_bound_ram (
    .clk(clk), .we(bd_we), .waddr(bd_waddr), .wdata(f_wval),
    .raddr(bd_raddr), .rdata(bd_rdata)
  );

  logic accept;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  logic wr_ok;
  assign wr_ok = accept && (s_axis_tuser == OP_WRITE) &&
                 (32'(f_entry) < MAX_OBJECTS) && (f_wsel <= WSEL_PLANE);
  assign ax_we    = wr_ok && (f_wsel == WSEL_AXIS);
  assign bd_we    = wr_ok && (f_wsel != WSEL_AXIS);
  assign ax_waddr = AW'(f_entry);
  assign bd_waddr = BAW'(32'(f_entry) * WORDS + 32'(f_wsel) - 1);

  // Entry base in bound RAM
  logic [AW-1:0] cur;
  assign cur = idx[AW-1:0];
  assign ax_raddr = cur;
  always_comb begin
    case (state)
      ST_MUL:  bd_raddr = BAW'(32'(cur) * WORDS);
      ST_BND:  bd_raddr = BAW'(32'(cur) * WORDS + 32'(sub[1:0]) + 1);
      default: bd_raddr = BAW'(32'(cur) * WORDS + 4);
    endcase
  end

  // Per-axis selection of normal and other axes
  logic [1:0] ia, ib;
  always_comb begin
    unique case (ax)
      AXIS_X:  begin ia = AXIS_Y; ib = AXIS_Z; end
      AXIS_Y:  begin ia = AXIS_X; ib = AXIS_Z; end
      default: begin ia = AXIS_X; ib = AXIS_Y; end
    endcase
  end

  // Plane check
  logic signed [CW:0]   num;
  logic signed [DW-1:0] dn;
  logic [NW-1:0] num_mag;
  logic [DW-1:0] dn_mag;
  logic [DW-1:0] dn_abs;
  logic          chk_ok;
  always_comb begin
    dn      = d[ax_rdata];
    num     = (CW+1)'(signed'(bd_rdata)) - (CW+1)'(o[ax_rdata]);
    dn_abs  = dn[DW-1] ? DW'(-dn) : dn;
    dn_mag  = dn_abs;
    num_mag = NW'(num[CW] ? -num : num) << FRAC_BITS;
    chk_ok  = (ax_rdata != 2'd3) && (dn != '0) && (num != '0) &&
              (num[CW] == dn[DW-1]) && (8'(cur) != 8'(excl));
  end

  logic          div_start, div_done;
  logic [NW-1:0] div_q;
  assign div_start = (state == ST_CHK) && chk_ok;
  crh_div #(.NW(NW), .DVW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num_mag), .den(dn_mag),
    .done(div_done), .quo(div_q)
  );

  // Shared multiplier: floor(dm * t / 2^F) with sign; one product per cycle
  logic signed [DW-1:0] m_d;
  logic signed [NW:0]   m_t;
  logic [DW-1:0]        m_dm;
  logic [NW-1:0]        m_tm;
  logic [DW+NW-1:0]     m_p;
  logic signed [71:0]   m_res;
  logic                 m_neg;
  always_comb begin
    m_dm  = m_d[DW-1] ? DW'(-m_d) : m_d;
    m_tm  = m_t[NW] ? NW'(-m_t) : m_t[NW-1:0];
    m_p   = (DW+NW)'(m_dm) * (DW+NW)'(m_tm);
    m_neg = (m_d[DW-1] != m_t[NW]) && (m_d != '0) && (m_t != '0);
    if (m_neg)
      m_res = -72'(signed'({1'b0, m_p >> FRAC_BITS})) -
              ((m_p[FRAC_BITS-1:0] != '0) ? 72'sd1 : 72'sd0);
    else
      m_res = 72'(signed'({1'b0, m_p >> FRAC_BITS}));
  end

  always_comb begin
    if (state == ST_PT) begin
      m_d = d[sub[1:0]];
      m_t = (NW+1)'(best_t) - (NW+1)'(BACKOFF);
    end else begin
      m_d = (sub == 3'd0) ? d[ia] : d[ib];
      m_t = (NW+1)'(tm);
    end
  end

  logic signed [71:0] coord;
  assign coord = 72'(o[state == ST_PT ? sub[1:0] : (sub == 3'd0 ? ia : ib)]) + m_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      object_count  <= '0;
      m_axis_tvalid <= 1'b0;
      found         <= 1'b0;
      idx           <= '0;
      sub           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) object_count <= cfg_data;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser == OP_TRACE) begin
              excl    <= s_axis_tdata[41:36];
              o[0]    <= s_axis_tdata[69:42];
              o[1]    <= s_axis_tdata[97:70];
              o[2]    <= s_axis_tdata[125:98];
              d[0]    <= s_axis_tdata[143:126];
              d[1]    <= s_axis_tdata[161:144];
              d[2]    <= s_axis_tdata[179:162];
              cnt_lim <= (32'(object_count) > MAX_OBJECTS) ? 7'(MAX_OBJECTS)
                                                            : 7'(object_count);
              idx     <= '0;
              found   <= 1'b0;
              best_t  <= '0;
              best_i  <= '0;
              best_ax <= '0;
              state   <= ST_NEXT;
            end else begin
              state <= ST_WR;
            end
          end
        end
        ST_WR: state <= ST_IDLE;
        ST_NEXT: begin
          sub <= '0;
          if (idx >= 8'(cnt_lim)) begin
            state <= ST_PT;
          end else begin
            state <= ST_RDAX;
          end
        end
        ST_RDAX: state <= ST_CHK;
        ST_CHK: begin
          ax <= ax_rdata;
          if (chk_ok) state <= ST_DIV;
          else begin
            idx   <= idx + 8'd1;
            state <= ST_NEXT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            tm <= div_q;
            if (div_q == '0) begin
              idx   <= idx + 8'd1;
              state <= ST_NEXT;
            end else begin
              sub   <= '0;
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          // sub 0: ca, sub 1: cb; RAM reads low a meanwhile
          if (sub == 3'd0) ca <= coord[CAW-1:0];
          else cb <= coord[CAW-1:0];
          if (sub == 3'd1) begin
            sub   <= '0;
            inb   <= 1'b1;
            state <= ST_BND;
          end else begin
            sub <= sub + 3'd1;
          end
        end
        ST_BND: begin
          // bd_rdata holds bound word sub (0 low a .. 3 high b)
          unique case (sub[1:0])
            2'd0: if (ca < CAW'(signed'(bd_rdata))) inb <= 1'b0;
            2'd1: if (ca > CAW'(signed'(bd_rdata))) inb <= 1'b0;
            2'd2: if (cb < CAW'(signed'(bd_rdata))) inb <= 1'b0;
            default: if (cb > CAW'(signed'(bd_rdata))) inb <= 1'b0;
          endcase
          sub <= sub + 3'd1;
          if (sub == 3'd3) begin
            if (inb && !(cb > CAW'(signed'(bd_rdata))) &&
                (!found || tm < best_t)) begin
              found   <= 1'b1;
              best_t  <= tm;
              best_i  <= cur;
              best_ax <= ax;
            end
            idx   <= idx + 8'd1;
            state <= ST_NEXT;
          end
        end
        ST_PT: begin
          unique case (sub[1:0])
            2'd0: out_data[67:40] <= sat_pt(coord);
            2'd1: out_data[95:68] <= sat_pt(coord);
            default: out_data[123:96] <= sat_pt(coord);
          endcase
          sub <= sub + 3'd1;
          if (sub == 3'd2) state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result assembly
  logic [30:0] dist_sat;
  assign dist_sat = (best_t > NW'(31'h7FFFFFFF)) ? 31'h7FFFFFFF : 31'(best_t);
  always_ff @(posedge clk) begin
    if (state == ST_OUT && !m_axis_tvalid) begin
      if (found) begin
        m_axis_tdata <= {4'd0, out_data[123:40], d[best_ax] >= 0, best_ax,
                         dist_sat, 5'(best_i), 1'b1};
      end else begin
        m_axis_tdata <= {4'd0, 84'd0, 1'b0, 2'd0, 31'h7FFFFFFF, 5'd0, 1'b0};
      end
    end
  end
endmodule

@@ rtl/crh_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
`timescale 1ns / 1ps
module crh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/crh_div.sv @@
// Serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module crh_div #(
  parameter int NW = 48,
  parameter int DVW = 17
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [NW-1:0]  num,
  input  logic [DVW-1:0] den,
  output logic           done,
  output logic [NW-1:0]  quo
);
  localparam int CNTW = $clog2(NW + 1);
  logic [NW-1:0]  q;
  logic [DVW:0]   r;
  logic [DVW-1:0] d;
  logic [CNTW-1:0] cnt;
  logic busy;
  logic [DVW:0] r_sh;

  assign r_sh = {r[DVW-1:0], q[NW-1]};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= num;
      r <= '0;
      d <= den;
    end else if (busy) begin
      if (r_sh >= {1'b0, d}) begin
        r <= r_sh - {1'b0, d};
        q <= {q[NW-2:0], 1'b1};
      end else begin
        r <= r_sh;
        q <= {q[NW-2:0], 1'b0};
      end
    end
  end
endmodule

@@ rtl/crh_checker.sv @@
// Port-level checker for the closest rectangle hit block, bound to the top level.
`timescale 1ns / 1ps
module crh_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");
  a_nohit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[36:1] == {31'h7FFFFFFF, 5'd0})
    else $error("miss result not canonical");
  a_hitdist: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[36:6] != 31'd0)
    else $error("hit with zero distance");
  a_axis: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[38:37] != 2'd3)
    else $error("bad normal axis");
endmodule

bind closest_rectangle_hit crh_checker u_crh_checker (
  .clk(clk), .rst(rst),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
